@@ design/fpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsc_pkg: shared constants and tables for the fixed-point sine/cosine block
// Holds the 1/(2pi) scale constant and the quarter-wave sine coefficient ROM.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int DataWidth = 32;
    localparam int FracWidth = 5;
    localparam int PipeDepth = 7;
    localparam logic [FracWidth-1:0] FracReset = 5'd16;
    localparam logic [31:0] InvTwoPi = 32'ha2f9836e;

    typedef logic [DataWidth-1:0] word_t;

    typedef struct packed {
        logic [32:0] c0;
        logic [31:0] c1;
        logic signed [31:0] c2;
        logic [31:0] c3;
        logic [31:0] c4;
    } coef_t;

    function automatic coef_t qsin_coef(input logic [3:0] seg);
        coef_t c;
        begin
            c = '0;
            case (seg)
                4'd0:  c = '{33'h000000001, 32'hc90fd9a3, 32'sh00003fb0,
                             32'ha58a7e76, 32'h065f386b};
                4'd1:  c = '{33'h01917a6bd, 32'hc817ffc8, -32'sh07bcf80f,
                             32'ha4be44bc, 32'h130df3a4};
                4'd2:  c = '{33'h031f17079, 32'hc532d541, -32'sh0f671be3,
                             32'ha25be1b9, 32'h1f8db4a9};
                4'd3:  c = '{33'h04a5018bc, 32'hc0677d57, -32'sh16eb464b,
                             32'h9e693649, 32'h2bbfaac2};
                4'd4:  c = '{33'h061f78a9b, 32'hb9c1c9f7, -32'sh1e36ef68,
                             32'h98effe28, 32'h3785c4f8};
                4'd5:  c = '{33'h078ad74e1, 32'hb1521e87, -32'sh25381aa7,
                             32'h91fdb7eb, 32'h42c2fc45};
                4'd6:  c = '{33'h08e39d9ce, 32'ha72d4786, -32'sh2bdd8320,
                             32'h89a383c5, 32'h4d5b9b12};
                4'd7:  c = '{33'h0a2679929, 32'h9b6c4741, -32'sh3216c622,
                             32'h7ff5f946, 32'h57358192};
                4'd8:  c = '{33'h0b504f334, 32'h8e2c182b, -32'sh37d48b9e,
                             32'h750cf49d, 32'h60386657};
                4'd9:  c = '{33'h0c5e40359, 32'h7f8d656d, -32'sh3d08abfa,
                             32'h69035bc2, 32'h684e11dd};
                4'd10: c = '{33'h0d4db3149, 32'h6fb43a5a, -32'sh41a652f5,
                             32'h5bf6dc22, 32'h6f629596};
                4'd11: c = '{33'h0e1c5978c, 32'h5ec7a990, -32'sh45a21f4a,
                             32'h4e07a17a, 32'h75647cec};
                4'd12: c = '{33'h0ec835e7a, 32'h4cf16ca9, -32'sh48f23ebf,
                             32'h3f580680, 32'h7a44f841};
                4'd13: c = '{33'h0f4fa0ab6, 32'h3a5d7d55, -32'sh4b8e8659,
                             32'h300c403c, 32'h7df801d6};
                4'd14: c = '{33'h0fb14be80, 32'h2739a8f5, -32'sh4d708680,
                             32'h204a04ae, 32'h80747a4c};
                default: c = '{33'h0fec46d1f, 32'h13b51fad, -32'sh4e939ae0,
                               32'h10382e0b, 32'h81b441c8};
            endcase
            return c;
        end
    endfunction

endpackage

@@ design/fixed_point_sine_cosine.sv @@
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine: pipelined fixed-point sine and cosine
// Input channel (in_valid/in_ready, kind, angle) takes one transaction per
// cycle while in_ready is high. Output channel (out_valid/out_ready, result)
// delivers one result per input, in order. The throughput is one item every
// cycle while out_ready is high, since all stages advance together on en.
// cfg_valid/cfg_ready write frac_bits (5 bits), which sets the fraction bits
// of both angle and result; write it only while the pipeline is empty.
// Reset clears all valid bits and sets frac_bits to 16.
// When out_ready is low and the output stage holds a result, the whole
// pipeline holds and in_ready falls; an empty output stage is still refilled,
// but bubbles further up the pipeline are kept.
// ----------------------------------------------------------------------------
module fixed_point_sine_cosine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] angle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [fpsc_pkg::FracWidth-1:0] cfg_data
);
    import fpsc_pkg::*;

    logic [FracWidth-1:0] frac_reg;
    logic [PipeDepth-1:0] vld_reg;
    logic                 en;

    assign cfg_ready = 1'b1;
    assign en        = out_ready || !vld_reg[PipeDepth-1];
    assign in_ready  = en;
    assign out_valid = vld_reg[PipeDepth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_reg <= FracReset;
        else if (cfg_valid)
            frac_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PipeDepth-2:0], in_valid};
    end

    fpsc_pipe u_pipe (
        .clk       (clk),
        .en        (en),
        .frac_bits (frac_reg),
        .kind      (kind),
        .angle     (angle),
        .result    (result)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted transaction lost");
endmodule

@@ design/fpsc_pipe.sv @@
// ----------------------------------------------------------------------------
// fpsc_pipe: sine/cosine datapath pipeline
// Seven register stages: scale, quadrant fold, powers, products, sum, output.
// All stages advance together on en.
// ----------------------------------------------------------------------------
module fpsc_pipe (
    input  logic                     clk,
    input  logic                     en,
    input  logic [fpsc_pkg::FracWidth-1:0] frac_bits,
    input  logic                     kind,
    input  logic [31:0]              angle,
    output logic [31:0]              result
);
    import fpsc_pkg::*;

    // stage 1: magnitude and scale product
    logic [63:0] s1_prod_reg;
    logic        s1_kind_reg, s1_neg_reg;
    logic [4:0]  s1_fb_reg;
    logic        neg;
    logic [31:0] mag;
    assign neg = angle[31];
    assign mag = neg ? (32'd0 - angle) : angle;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= {32'd0, mag} * {32'd0, InvTwoPi};
            s1_kind_reg <= kind;
            s1_neg_reg  <= neg;
            s1_fb_reg   <= frac_bits;
        end
    end

    // stage 2: turn fraction, quadrant, folded argument
    logic [63:0] turn64;
    logic [31:0] turn, targ;
    logic [1:0]  quad;
    assign turn64 = s1_prod_reg >> ({1'b0, s1_fb_reg} + 6'd2);
    assign turn   = turn64[31:0];
    assign quad   = turn[31:30] + {1'b0, s1_kind_reg};
    assign targ   = quad[0] ? (32'hffffffff - {turn[29:0], 2'b00}) : {turn[29:0], 2'b00};
    logic [31:0] s2_p1_reg;
    logic [3:0]  s2_seg_reg;
    logic        s2_negout_reg;
    logic [4:0]  s2_fb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_p1_reg     <= {targ[27:0], 4'd0};
            s2_seg_reg    <= targ[31:28];
            s2_negout_reg <= quad[1] ^ (~s1_kind_reg & s1_neg_reg);
            s2_fb_reg     <= s1_fb_reg;
        end
    end

    // stage 3: p2
    logic [63:0] sq1;
    assign sq1 = {32'd0, s2_p1_reg} * {32'd0, s2_p1_reg};
    logic [31:0] s3_p1_reg, s3_p2_reg;
    logic [3:0]  s3_seg_reg;
    logic        s3_negout_reg;
    logic [4:0]  s3_fb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_p1_reg     <= s2_p1_reg;
            s3_p2_reg     <= sq1[63:32];
            s3_seg_reg    <= s2_seg_reg;
            s3_negout_reg <= s2_negout_reg;
            s3_fb_reg     <= s2_fb_reg;
        end
    end

    // stage 4: p3, p4
    logic [63:0] m3, m4;
    assign m3 = {32'd0, s3_p2_reg} * {32'd0, s3_p1_reg};
    assign m4 = {32'd0, s3_p2_reg} * {32'd0, s3_p2_reg};
    logic [31:0] s4_p1_reg, s4_p2_reg, s4_p3_reg, s4_p4_reg;
    logic [3:0]  s4_seg_reg;
    logic        s4_negout_reg;
    logic [4:0]  s4_fb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_p1_reg     <= s3_p1_reg;
            s4_p2_reg     <= s3_p2_reg;
            s4_p3_reg     <= m3[63:32];
            s4_p4_reg     <= m4[63:32];
            s4_seg_reg    <= s3_seg_reg;
            s4_negout_reg <= s3_negout_reg;
            s4_fb_reg     <= s3_fb_reg;
        end
    end

    // stage 5: coefficient products, truncated
    coef_t c;
    assign c = qsin_coef(s4_seg_reg);
    logic [63:0] t1, t3, t4;
    logic signed [64:0] t2;
    assign t1 = {32'd0, c.c1} * {32'd0, s4_p1_reg};
    assign t2 = $signed({{33{c.c2[31]}}, c.c2}) * $signed({33'd0, s4_p2_reg});
    assign t3 = {32'd0, c.c3} * {32'd0, s4_p3_reg};
    assign t4 = {32'd0, c.c4} * {32'd0, s4_p4_reg};
    logic [30:0] s5_a1_reg;
    logic signed [28:0] s5_a2_reg;
    logic [21:0] s5_a3_reg;
    logic [16:0] s5_a4_reg;
    logic [32:0] s5_c0_reg;
    logic        s5_negout_reg;
    logic [4:0]  s5_fb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_a1_reg     <= t1[63:33];
            s5_a2_reg     <= t2[64:36];
            s5_a3_reg     <= t3[63:42];
            s5_a4_reg     <= t4[63:47];
            s5_c0_reg     <= c.c0;
            s5_negout_reg <= s4_negout_reg;
            s5_fb_reg     <= s4_fb_reg;
        end
    end

    // stage 6: accumulate, round, rescale
    logic signed [37:0] sum;
    logic signed [37:0] rnd;
    logic [31:0] q, mo;
    assign sum = $signed({7'd0, s5_a1_reg}) + 38'(s5_a2_reg) - $signed({16'd0, s5_a3_reg})
               + $signed({21'd0, s5_a4_reg}) + $signed({3'd0, s5_c0_reg, 2'b00});
    assign rnd = (sum + 38'sd4) >>> 3;
    assign q   = rnd[31:0];
    assign mo  = q >> (5'd31 - s5_fb_reg);
    logic [31:0] s6_mag_reg;
    logic        s6_negout_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_mag_reg    <= mo;
            s6_negout_reg <= s5_negout_reg;
        end
    end

    // stage 7: sign and saturate
    logic [31:0] res;
    always_comb
    begin
        if (s6_negout_reg)
            res = 32'd0 - s6_mag_reg;
        else if (s6_mag_reg[31])
            res = 32'h7fffffff;
        else
            res = s6_mag_reg;
        if (s6_negout_reg && s6_mag_reg[31])
            res = 32'h80000000;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            result <= res;
    end
endmodule

@@ dv/fixed_point_sine_cosine_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_point_sine_cosine_tb: self-checking bench for the sine/cosine block
// Drives angle/kind transactions with random gaps, predicts each result with
// a local bit-accurate model of the quadrant fold and segment polynomial,
// and compares results in order. Sweeps frac_bits across several settings.
// ----------------------------------------------------------------------------
module fixed_point_sine_cosine_tb;

    import fpsc_pkg::*;

    localparam logic KindSin = 1'b0;
    localparam logic KindCos = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] angle;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [FracWidth-1:0] cfg_data;

    logic [FracWidth-1:0] cur_frac;
    logic [31:0] pending_results[$];
    int          mismatches;
    int          hold_off_cycles;
    int          stall_req_count;
    int          stall_ack_count;

    fixed_point_sine_cosine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint floor_div_pow2(longint v, int n);
        return v >>> n;
    endfunction

    // segment ROM values kept locally, independent of the package function
    function automatic longint seg_coef(int seg, int idx);
        longint rom[16][5];
        rom = '{
            '{64'h00000001, 64'hc90fd9a3, 64'h00003fb0, 64'ha58a7e76, 64'h065f386b},
            '{64'h1917a6bd, 64'hc817ffc8, -64'h07bcf80f, 64'ha4be44bc, 64'h130df3a4},
            '{64'h31f17079, 64'hc532d541, -64'h0f671be3, 64'ha25be1b9, 64'h1f8db4a9},
            '{64'h4a5018bc, 64'hc0677d57, -64'h16eb464b, 64'h9e693649, 64'h2bbfaac2},
            '{64'h61f78a9b, 64'hb9c1c9f7, -64'h1e36ef68, 64'h98effe28, 64'h3785c4f8},
            '{64'h78ad74e1, 64'hb1521e87, -64'h25381aa7, 64'h91fdb7eb, 64'h42c2fc45},
            '{64'h8e39d9ce, 64'ha72d4786, -64'h2bdd8320, 64'h89a383c5, 64'h4d5b9b12},
            '{64'ha2679929, 64'h9b6c4741, -64'h3216c622, 64'h7ff5f946, 64'h57358192},
            '{64'hb504f334, 64'h8e2c182b, -64'h37d48b9e, 64'h750cf49d, 64'h60386657},
            '{64'hc5e40359, 64'h7f8d656d, -64'h3d08abfa, 64'h69035bc2, 64'h684e11dd},
            '{64'hd4db3149, 64'h6fb43a5a, -64'h41a652f5, 64'h5bf6dc22, 64'h6f629596},
            '{64'he1c5978c, 64'h5ec7a990, -64'h45a21f4a, 64'h4e07a17a, 64'h75647cec},
            '{64'hec835e7a, 64'h4cf16ca9, -64'h48f23ebf, 64'h3f580680, 64'h7a44f841},
            '{64'hf4fa0ab6, 64'h3a5d7d55, -64'h4b8e8659, 64'h300c403c, 64'h7df801d6},
            '{64'hfb14be80, 64'h2739a8f5, -64'h4d708680, 64'h204a04ae, 64'h80747a4c},
            '{64'hfec46d1f, 64'h13b51fad, -64'h4e939ae0, 64'h10382e0b, 64'h81b441c8}};
        return rom[seg][idx];
    endfunction

    function automatic logic [31:0] quarter_wave(logic [31:0] t);
        int          seg;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [63:0] prod;
        longint      acc;
        seg  = int'(t[31:28]);
        p1   = t << 4;
        prod = 64'(p1) * 64'(p1);
        p2   = prod[63:32];
        prod = 64'(p2) * 64'(p1);
        p3   = prod[63:32];
        prod = 64'(p2) * 64'(p2);
        p4   = prod[63:32];
        prod = 64'(seg_coef(seg, 1)) * 64'(p1);
        acc  = longint'(prod >> 33);
        acc += floor_div_pow2(seg_coef(seg, 2) * longint'({32'd0, p2}), 36);
        prod = 64'(seg_coef(seg, 3)) * 64'(p3);
        acc -= longint'(prod >> 42);
        prod = 64'(seg_coef(seg, 4)) * 64'(p4);
        acc += longint'(prod >> 47);
        acc += seg_coef(seg, 0) * 4;
        return 32'(floor_div_pow2(acc + 4, 3));
    endfunction

    function automatic logic [31:0] predict_trig(logic k, logic [31:0] a,
                                                 logic [FracWidth-1:0] fb);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] turn;
        logic [1:0]  quad;
        logic [31:0] mag_out;
        longint      s;
        neg  = a[31];
        mag  = neg ? 32'd0 - a : a;
        prod = (64'(mag) * 64'(InvTwoPi)) >> (int'(fb) + 2);
        turn = prod[31:0];
        quad = turn[31:30] + 2'(k);
        if (quad[0])
            mag_out = quarter_wave(32'hffffffff - (turn << 2));
        else
            mag_out = quarter_wave(turn << 2);
        mag_out = mag_out >> (31 - int'(fb));
        s = longint'({32'd0, mag_out});
        if (quad > 2'd1)
            s = -s;
        if (k == KindSin && neg)
            s = -s;
        if (s > 64'sh7fffffff)
            s = 64'sh7fffffff;
        if (s < -64'sh80000000)
            s = -64'sh80000000;
        return s[31:0];
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays high between back-to-back transactions; it drops only for a gap
    task automatic send_angle(logic k, logic [31:0] a);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        angle    <= a;
        pending_results.push_back(predict_trig(k, a, cur_frac));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PipeDepth + 3) @(posedge clk);
    endtask

    task automatic write_frac(logic [FracWidth-1:0] fb);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= fb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_frac = fb;
    endtask

    function automatic logic [31:0] rand_angle(logic [FracWidth-1:0] fb);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            // within a few turns of zero, the well-behaved range
            return 32'($urandom) >>> (31 - (int'(fb) < 28 ? int'(fb) + 3 : 31));
        if (r < 7)
            return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 15)
                                        : 32'h80000000 + $urandom_range(0, 15);
        return $urandom;
    endfunction

    task automatic test_directed();
        logic [31:0] edges[10];
        edges = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                  32'h80000001, 32'h00010000, 32'hfffe0000, 32'h55555555, 32'haaaaaaaa};
        foreach (edges[i])
        begin
            send_angle(KindSin, edges[i]);
            send_angle(KindCos, edges[i]);
        end
    endtask

    task automatic test_unity_saturation();
        write_frac(5'd31);
        send_angle(KindCos, 32'h0);
        send_angle(KindSin, 32'h0);
        send_angle(KindCos, 32'h80000000);
        send_angle(KindSin, 32'h7fffffff);
        send_angle(KindSin, 32'h80000000);
    endtask

    task automatic test_random_sweep();
        logic [FracWidth-1:0] settings[8];
        logic [FracWidth-1:0] fb;
        settings = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd30, 5'd8, 5'd24, 5'd12};
        foreach (settings[i])
        begin
            write_frac(settings[i]);
            repeat (150) send_angle(1'($urandom), rand_angle(settings[i]));
        end
        fb = 5'($urandom);
        write_frac(fb);
        repeat (100) send_angle(1'($urandom), $urandom);
    endtask

    task automatic test_backpressure();
        write_frac(5'd20);
        stall_req_count = stall_req_count + 1;
        repeat (40)
        begin
            in_valid <= 1'b1;
            kind     <= 1'($urandom);
            angle    <= rand_angle(5'd20);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            pending_results.push_back(predict_trig(kind, angle, 5'd20));
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready       <= 1'b0;
            hold_off_cycles <= 0;
            stall_ack_count <= 0;
        end
        else if (stall_req_count != stall_ack_count)
        begin
            stall_ack_count <= stall_req_count;
            hold_off_cycles <= 60;
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 8)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
        begin
            hold_off_cycles <= $urandom_range(5, 25);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, result);
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("fixed_point_sine_cosine verification failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        kind            = 1'b0;
        angle           = 32'd0;
        cfg_valid       = 1'b0;
        cfg_data        = FracReset;
        cur_frac        = FracReset;
        mismatches      = 0;
        stall_req_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_unity_saturation();
        test_backpressure();
        test_random_sweep();
        drain();
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("fixed_point_sine_cosine verification clean");
        else
            $display("fixed_point_sine_cosine verification failed");
        $finish;
    end

endmodule
